[rtl/lhfs_pkg.sv]
// shared types and constants of the low/high frame selector
package lhfs_pkg;

  // datapath width of frame numbers and periods
  localparam int DATA_W = 32;

  // default depth of the frame fifo
  localparam int FIFO_DEPTH_DEF = 16;

  // operation codes
  localparam logic [2:0] OP_CHECK_SEND = 3'd0;
  localparam logic [2:0] OP_PUT        = 3'd1;
  localparam logic [2:0] OP_COMPUTE    = 3'd2;
  localparam logic [2:0] OP_POLL       = 3'd3;
  localparam logic [2:0] OP_TAKE       = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
  localparam logic [1:0] ST_NOT_MASTER = 2'd3;

  // register indexes
  localparam logic [1:0] REG_LOW_PERIOD  = 2'd0;
  localparam logic [1:0] REG_HIGH_PERIOD = 2'd1;
  localparam logic [1:0] REG_IS_MASTER   = 2'd2;

  // register reset values
  localparam logic [DATA_W-1:0] LOW_PERIOD_RST  = 32'd10;
  localparam logic [DATA_W-1:0] HIGH_PERIOD_RST = 32'd1;
  localparam logic              IS_MASTER_RST   = 1'b1;

  // divider request and result
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_res_t;

endpackage

[rtl/lhfs_divider.sv]
// iterative restoring divider, one quotient bit per cycle
module lhfs_divider
  import lhfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_res_t res
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  // one shift and trial subtract per cycle; a zero divisor gives all ones and the dividend
  always_comb begin
    trial    = {rem_r, quo_r[DATA_W-1]};
    diff     = trial - {1'b0, den_r};
    fits     = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_W);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

[rtl/low_high_frame_selector_top.sv]
// low/high frame selector: frame fifo, sequencer and configuration registers
//
// One request on the in_ channel (valid/ready) carries an operation, a frame
// number and a channel value; exactly one result request leaves on the out_
// channel for each. Requests are worked one at a time by a small sequencer
// around a shared divider and a frame memory with one write and one read port,
// which gives one read a cycle. A put writes the memory unless the fifo is
// full, check_send runs one division, poll and take scan the buffered frames
// oldest first, and compute takes at most two quotients, then a remainder per
// scanned frame. in_ready is high only while the sequencer is idle, so the
// next request can be taken in the cycle in which a result is presented. A
// finished result sits in an output register; the next request is accepted
// while it waits, and the sequencer holds its own result until the receiver
// has taken the earlier one, so a stalled receiver adds its stall cycles to
// the latency. Registers sit on an APB-style port (low_period at 0x0,
// high_period at 0x4, is_master at 0x8), to be written only while the block
// is idle; the block itself does not enforce this. Reset (synchronous,
// active low) restores the register defaults and empties the fifo; the frame
// memory itself is not cleared and needs no sweep.
module low_high_frame_selector_top
  import lhfs_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_operation,
  input  logic [DATA_W-1:0]        in_frame_id,
  input  logic signed [DATA_W-1:0] in_channel_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_send_ok,
  output logic                     out_ready_res,
  output logic [DATA_W-1:0]        out_chosen_frame,
  output logic [1:0]               out_status,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = $clog2(2 * FIFO_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECODE   = 10'b00_0000_0010,
    S_NEWEST   = 10'b00_0000_0100,
    S_DIV_SEND = 10'b00_0000_1000,
    S_DIV_NEW  = 10'b00_0001_0000,
    S_DIV_PREV = 10'b00_0010_0000,
    S_SCAN_RD  = 10'b00_0100_0000,
    S_SCAN_CHK = 10'b00_1000_0000,
    S_DIV_SCAN = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  // ring index of the entry off places after the head
  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(off);
    if (sum >= SW'(FIFO_DEPTH)) sum = sum - SW'(FIFO_DEPTH);
    return sum[AW-1:0];
  endfunction

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] low_period_r, low_period_nxt;
  logic [DATA_W-1:0] high_period_r, high_period_nxt;
  logic              is_master_r, is_master_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0] prev_r, prev_nxt;
  logic              prev_valid_r, prev_valid_nxt;
  logic [DATA_W-1:0] target_r, target_nxt;
  logic              target_known_r, target_known_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [2:0]        op_r, op_nxt;
  logic [DATA_W-1:0] fid_r, fid_nxt;
  logic [DATA_W-1:0] chan_r, chan_nxt;
  logic [CW-1:0]     scan_idx_r, scan_idx_nxt;
  logic [DATA_W-1:0] newest_r, newest_nxt;
  logic [DATA_W-1:0] qa_r, qa_nxt;
  logic              res_send_ok_r, res_send_ok_nxt;
  logic              res_ready_r, res_ready_nxt;
  logic [DATA_W-1:0] res_chosen_r, res_chosen_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic              out_send_ok_r, out_send_ok_nxt;
  logic              out_ready_res_r, out_ready_res_nxt;
  logic [DATA_W-1:0] out_chosen_r, out_chosen_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic [DATA_W-1:0] frame_mem [FIFO_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;

  div_req_t          div_req;
  div_res_t          div_res;
  logic              cfg_wr;
  logic [DATA_W-1:0] prev_cmp;
  logic              poll_hit;
  logic [CW-1:0]     idx_inc;

  // shared divider
  lhfs_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // register writes and reads
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_LOW_PERIOD:  prdata = low_period_r;
      REG_HIGH_PERIOD: prdata = high_period_r;
      REG_IS_MASTER:   prdata = {{(DATA_W-1){1'b0}}, is_master_r};
      default:         prdata = '0;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign prev_cmp = prev_valid_r ? prev_r : '1;
  assign poll_hit = (chan_r != prev_cmp);
  assign idx_inc  = scan_idx_r + CW'(1);

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    low_period_nxt    = low_period_r;
    high_period_nxt   = high_period_r;
    is_master_nxt     = is_master_r;
    head_nxt          = head_r;
    count_nxt         = count_r;
    prev_nxt          = prev_r;
    prev_valid_nxt    = prev_valid_r;
    target_nxt        = target_r;
    target_known_nxt  = target_known_r;
    out_valid_nxt     = out_valid_r;
    op_nxt            = op_r;
    fid_nxt           = fid_r;
    chan_nxt          = chan_r;
    scan_idx_nxt      = scan_idx_r;
    newest_nxt        = newest_r;
    qa_nxt            = qa_r;
    res_send_ok_nxt   = res_send_ok_r;
    res_ready_nxt     = res_ready_r;
    res_chosen_nxt    = res_chosen_r;
    res_status_nxt    = res_status_r;
    out_send_ok_nxt   = out_send_ok_r;
    out_ready_res_nxt = out_ready_res_r;
    out_chosen_nxt    = out_chosen_r;
    out_status_nxt    = out_status_r;
    mem_we            = 1'b0;
    mem_waddr         = slot_f(head_r, count_r);
    mem_raddr         = slot_f(head_r, scan_idx_r);
    div_req           = '0;

    // output register drains when taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // configuration writes
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_LOW_PERIOD:  low_period_nxt  = pwdata;
        REG_HIGH_PERIOD: high_period_nxt = pwdata;
        REG_IS_MASTER:   is_master_nxt   = pwdata[0];
        default:         ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt          = in_operation;
          fid_nxt         = in_frame_id;
          chan_nxt        = $unsigned(in_channel_value);
          res_send_ok_nxt = 1'b0;
          res_ready_nxt   = 1'b0;
          res_chosen_nxt  = '0;
          res_status_nxt  = ST_OK;
          state_nxt       = S_DECODE;
        end
      end

      S_DECODE: begin
        case (op_r)
          OP_CHECK_SEND: begin
            div_req.start    = 1'b1;
            div_req.dividend = fid_r;
            div_req.divisor  = high_period_r;
            state_nxt        = S_DIV_SEND;
          end
          OP_PUT: begin
            if (count_r >= CW'(FIFO_DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
            state_nxt = S_DONE;
          end
          OP_COMPUTE: begin
            if (!is_master_r) begin
              res_status_nxt = ST_NOT_MASTER;
              state_nxt      = S_DONE;
            end else if (count_r == '0) begin
              res_chosen_nxt = prev_valid_r ? prev_r + DATA_W'(1) : '0;
              state_nxt      = S_DONE;
            end else begin
              mem_raddr = slot_f(head_r, count_r - CW'(1));
              state_nxt = S_NEWEST;
            end
          end
          OP_POLL: begin
            // no target: latch chan unless it is the previous frame, or -1 if none
            if (!target_known_r && poll_hit) begin
              target_known_nxt = 1'b1;
              target_nxt       = chan_r;
            end
            scan_idx_nxt = '0;
            state_nxt    = (target_known_r || poll_hit) ? S_SCAN_RD : S_DONE;
          end
          OP_TAKE: begin
            res_chosen_nxt   = target_r;
            prev_nxt         = target_r;
            prev_valid_nxt   = 1'b1;
            target_known_nxt = 1'b0;
            scan_idx_nxt     = '0;
            state_nxt        = S_SCAN_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end

      // newest entry read: test its low period against a previous frame, else scan
      S_NEWEST: begin
        newest_nxt = rd_data_r;
        if (prev_valid_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = rd_data_r;
          div_req.divisor  = low_period_r;
          state_nxt        = S_DIV_NEW;
        end else begin
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN_RD;
        end
      end

      S_DIV_SEND: begin
        if (div_res.done) begin
          res_send_ok_nxt = (div_res.remainder == '0);
          state_nxt       = S_DONE;
        end
      end

      S_DIV_NEW: begin
        if (div_res.done) begin
          qa_nxt           = div_res.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = prev_r;
          div_req.divisor  = low_period_r;
          state_nxt        = S_DIV_PREV;
        end
      end

      S_DIV_PREV: begin
        if (div_res.done) begin
          if (div_res.quotient == qa_r) begin
            res_chosen_nxt = newest_r;
            state_nxt      = S_DONE;
          end else begin
            scan_idx_nxt = '0;
            state_nxt    = S_SCAN_RD;
          end
        end
      end

      // scan from the oldest entry; the end of the fifo means no match
      S_SCAN_RD: begin
        if (scan_idx_r == count_r) begin
          case (op_r)
            OP_COMPUTE: res_chosen_nxt = newest_r;
            OP_TAKE: begin
              head_nxt       = '0;
              count_nxt      = '0;
              res_status_nxt = ST_NOT_FOUND;
            end
            default: ;
          endcase
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end

      // read data holds while the scan index stays put
      S_SCAN_CHK: begin
        if (op_r == OP_COMPUTE) begin
          div_req.start    = 1'b1;
          div_req.dividend = rd_data_r;
          div_req.divisor  = low_period_r;
          state_nxt        = S_DIV_SCAN;
        end else if (rd_data_r == target_r) begin
          if (op_r == OP_TAKE) begin
            head_nxt  = slot_f(head_r, idx_inc);
            count_nxt = count_r - idx_inc;
          end else begin
            res_ready_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          scan_idx_nxt = idx_inc;
          state_nxt    = S_SCAN_RD;
        end
      end

      S_DIV_SCAN: begin
        if (div_res.done) begin
          if (div_res.remainder == '0) begin
            res_chosen_nxt = rd_data_r;
            state_nxt      = S_DONE;
          end else begin
            scan_idx_nxt = idx_inc;
            state_nxt    = S_SCAN_RD;
          end
        end
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_send_ok_nxt   = res_send_ok_r;
          out_ready_res_nxt = res_ready_r;
          out_chosen_nxt    = res_chosen_r;
          out_status_nxt    = res_status_r;
          state_nxt         = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // frame memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[mem_waddr] <= fid_r;
    rd_data_r <= frame_mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      low_period_r   <= LOW_PERIOD_RST;
      high_period_r  <= HIGH_PERIOD_RST;
      is_master_r    <= IS_MASTER_RST;
      head_r         <= '0;
      count_r        <= '0;
      prev_r         <= '0;
      prev_valid_r   <= 1'b0;
      target_r       <= '0;
      target_known_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      low_period_r   <= low_period_nxt;
      high_period_r  <= high_period_nxt;
      is_master_r    <= is_master_nxt;
      head_r         <= head_nxt;
      count_r        <= count_nxt;
      prev_r         <= prev_nxt;
      prev_valid_r   <= prev_valid_nxt;
      target_r       <= target_nxt;
      target_known_r <= target_known_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    op_r            <= op_nxt;
    fid_r           <= fid_nxt;
    chan_r          <= chan_nxt;
    scan_idx_r      <= scan_idx_nxt;
    newest_r        <= newest_nxt;
    qa_r            <= qa_nxt;
    res_send_ok_r   <= res_send_ok_nxt;
    res_ready_r     <= res_ready_nxt;
    res_chosen_r    <= res_chosen_nxt;
    res_status_r    <= res_status_nxt;
    out_send_ok_r   <= out_send_ok_nxt;
    out_ready_res_r <= out_ready_res_nxt;
    out_chosen_r    <= out_chosen_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_send_ok      = out_send_ok_r;
  assign out_ready_res    = out_ready_res_r;
  assign out_chosen_frame = out_chosen_r;
  assign out_status       = out_status_r;

  // fifo fill never passes its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(FIFO_DEPTH))
    else $error("fifo count beyond depth");

  // one request at a time: accepting closes the input
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after accept");

  // divider results only arrive while the sequencer waits for them
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV_SEND || state_r == S_DIV_NEW ||
                      state_r == S_DIV_PREV || state_r == S_DIV_SCAN))
    else $error("divider result outside a wait state");

  // a result is presented only from the hand-over state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented outside hand-over");

endmodule

[tb/low_high_frame_selector_top_tb.sv]
// testbench of the low/high frame selector: directed table, random rounds, predictor check
`timescale 1ns / 100ps

module low_high_frame_selector_top_tb;
  import lhfs_pkg::*;

  localparam int SEL_DEPTH = FIFO_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_ITEMS = 90;
  localparam int PEND_SLOTS = 8;
  localparam int DIR_ROWS = 32;
  localparam logic [31:0] CHAN_MASK = 32'h7FFF_FFFF;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  // one result request of the block
  typedef struct packed {
    logic        send_ok;
    logic        ready_res;
    logic [31:0] chosen;
    logic [1:0]  status;
  } sel_res_t;

  // one row of the directed stimulus table
  typedef struct {
    logic [2:0]  op;
    logic [31:0] fid;
    logic [31:0] chan;
    int          reps;
    bit          typed;
    sel_res_t    res;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        in_operation;
  logic [31:0]       in_frame_id;
  logic signed [31:0] in_channel_value;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_send_ok;
  logic              out_ready_res;
  logic [31:0]       out_chosen_frame;
  logic [1:0]        out_status;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // selector model state and register copies
  logic [31:0] fs_store [SEL_DEPTH];
  int          fs_head;
  int          fs_count;
  logic [31:0] fs_prev;
  bit          fs_prev_ok;
  logic [31:0] fs_tgt;
  bit          fs_tgt_ok;
  logic [31:0] fs_low;
  logic [31:0] fs_high;
  bit          fs_master;

  // stimulus bookkeeping: awaited results in a ring, write and read counts
  sel_res_t    awaited_sel [PEND_SLOTS];
  int          pend_wr;
  int          pend_rd;
  stim_row_t   dir_tab [DIR_ROWS];
  int          dir_rows;
  logic [31:0] prod_frame;
  logic [31:0] ann_frame;
  int          items_sent;
  int          err_cnt;
  int          in_idle_pct;
  int          out_idle_pct;

  low_high_frame_selector_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_frame_id      (in_frame_id),
    .in_channel_value (in_channel_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_send_ok      (out_send_ok),
    .out_ready_res    (out_ready_res),
    .out_chosen_frame (out_chosen_frame),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("FAILURE");
    $finish;
  end

  // divide and remainder with the all-ones quotient on a zero divisor
  function automatic logic [31:0] period_index(logic [31:0] a, logic [31:0] b);
    return (b == 32'd0) ? 32'hFFFF_FFFF : a / b;
  endfunction

  function automatic logic [31:0] period_offset(logic [31:0] a, logic [31:0] b);
    return (b == 32'd0) ? a : a % b;
  endfunction

  // position of a frame in the fifo, oldest first, or -1
  function automatic int find_frame(logic [31:0] f);
    int i;
    for (i = 0; i < fs_count; i++) begin
      if (fs_store[(fs_head + i) % SEL_DEPTH] == f) return i;
    end
    return -1;
  endfunction

  // next selector result, updates the model state
  function automatic sel_res_t predict_selection(logic [2:0] op, logic [31:0] fid,
                                                 logic [31:0] chan);
    sel_res_t    r;
    logic [31:0] newest;
    logic [31:0] v;
    logic [31:0] prev_cmp;
    int          i;
    int          idx;
    bit          hit;
    r = '0;
    case (op)
      OP_CHECK_SEND: begin
        r.send_ok = (period_offset(fid, fs_high) == 32'd0);
      end
      OP_PUT: begin
        if (fs_count >= SEL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          fs_store[(fs_head + fs_count) % SEL_DEPTH] = fid;
          fs_count++;
        end
      end
      OP_COMPUTE: begin
        if (!fs_master) begin
          r.status = ST_NOT_MASTER;
        end else if (fs_count == 0) begin
          r.chosen = fs_prev_ok ? fs_prev + 32'd1 : 32'd0;
        end else begin
          newest = fs_store[(fs_head + fs_count - 1) % SEL_DEPTH];
          r.chosen = newest;
          // outside the previous low period: oldest multiple, else newest
          if (!(fs_prev_ok &&
                period_index(newest, fs_low) == period_index(fs_prev, fs_low))) begin
            hit = 1'b0;
            for (i = 0; i < fs_count; i++) begin
              v = fs_store[(fs_head + i) % SEL_DEPTH];
              if (!hit && period_offset(v, fs_low) == 32'd0) begin
                r.chosen = v;
                hit = 1'b1;
              end
            end
          end
        end
      end
      OP_POLL: begin
        if (!fs_tgt_ok) begin
          prev_cmp = fs_prev_ok ? fs_prev : 32'hFFFF_FFFF;
          if (chan != prev_cmp) begin
            fs_tgt_ok = 1'b1;
            fs_tgt = chan;
          end
        end
        if (fs_tgt_ok) r.ready_res = (find_frame(fs_tgt) >= 0);
      end
      OP_TAKE: begin
        r.chosen = fs_tgt;
        fs_prev = fs_tgt;
        fs_prev_ok = 1'b1;
        fs_tgt_ok = 1'b0;
        idx = find_frame(fs_tgt);
        if (idx >= 0) begin
          fs_head = (fs_head + idx + 1) % SEL_DEPTH;
          fs_count -= idx + 1;
        end else begin
          fs_head = 0;
          fs_count = 0;
          r.status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic sel_res_t mk_res(logic so, logic rr, logic [31:0] ch, logic [1:0] st);
    sel_res_t r;
    r.send_ok = so;
    r.ready_res = rr;
    r.chosen = ch;
    r.status = st;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [31:0] fid, logic [31:0] chan,
                                  int reps, bit typed, sel_res_t res);
    stim_row_t row;
    row.op = op;
    row.fid = fid;
    row.chan = chan;
    row.reps = reps;
    row.typed = typed;
    row.res = res;
    dir_tab[dir_rows] = row;
    dir_rows++;
  endfunction

  // channel value for a field the operation ignores
  function automatic logic [31:0] spare_chan();
    return ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : ($urandom() & CHAN_MASK);
  endfunction

  // channel value for a poll, most often the announced frame
  function automatic logic [31:0] pick_chan();
    int k;
    k = $urandom_range(99);
    if (k < 40) return ann_frame & CHAN_MASK;
    if (k < 65 && fs_count > 0)
      return fs_store[(fs_head + $urandom_range(fs_count - 1)) % SEL_DEPTH] & CHAN_MASK;
    if (k < 75) return 32'hFFFF_FFFF;
    if (k < 85) return fs_prev & CHAN_MASK;
    return $urandom() & CHAN_MASK;
  endfunction

  function automatic logic [31:0] pick_check_fid();
    int k;
    k = $urandom_range(99);
    if (k < 40) return fs_high * $urandom_range(50);
    if (k < 70) return prod_frame;
    return $urandom();
  endfunction

  // drive one request, predict its result once accepted
  task automatic send_req(input logic [2:0] op, input logic [31:0] fid,
                          input logic [31:0] chan, input bit typed = 1'b0,
                          input sel_res_t typed_res = '0);
    sel_res_t r;
    in_valid <= 1'b1;
    in_operation <= op;
    in_frame_id <= fid;
    in_channel_value <= chan;
    do @(posedge clk); while (in_ready !== 1'b1);
    r = predict_selection(op, fid, chan);
    if (op == OP_COMPUTE && r.status == ST_OK) ann_frame = r.chosen;
    awaited_sel[pend_wr % PEND_SLOTS] = typed ? typed_res : r;
    pend_wr++;
    items_sent++;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
  endtask

  task automatic put_next();
    send_req(OP_PUT, prod_frame, spare_chan());
    prod_frame = prod_frame + (($urandom_range(3) == 0) ? $urandom_range(2, 5) : 1);
  endtask

  // one producer/consumer round, a burst of puts, or a single odd request
  task automatic random_round();
    int k;
    k = $urandom_range(99);
    if (k < 60) begin
      repeat ($urandom_range(1, 4)) put_next();
      if ($urandom_range(99) < 30) send_req(OP_CHECK_SEND, pick_check_fid(), spare_chan());
      send_req(OP_COMPUTE, $urandom(), spare_chan());
      send_req(OP_POLL, $urandom(), ann_frame & CHAN_MASK);
      if ($urandom_range(99) < 20) send_req(OP_POLL, $urandom(), pick_chan());
      if ($urandom_range(99) < 85) send_req(OP_TAKE, $urandom(), spare_chan());
    end else begin
      k = $urandom_range(99);
      if (k < 15) put_next();
      else if (k < 22) send_req(OP_PUT, $urandom(), spare_chan());
      else if (k < 26) repeat ($urandom_range(16, 18)) put_next();
      else if (k < 44) send_req(OP_CHECK_SEND, pick_check_fid(), spare_chan());
      else if (k < 60) send_req(OP_COMPUTE, $urandom(), spare_chan());
      else if (k < 80) send_req(OP_POLL, $urandom(), pick_chan());
      else if (k < 94) send_req(OP_TAKE, $urandom(), spare_chan());
      else send_req(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), $urandom(),
                    spare_chan());
    end
  endtask

  // register write, back-to-back with the next one
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_LOW_PERIOD:  fs_low = val;
      REG_HIGH_PERIOD: fs_high = val;
      REG_IS_MASTER:   fs_master = val[0];
      default: begin
      end
    endcase
  endtask

  task automatic cfg_apply(input logic [31:0] lo, input logic [31:0] hi, input bit mst);
    cfg_write(REG_LOW_PERIOD, lo);
    cfg_write(REG_HIGH_PERIOD, hi);
    cfg_write(REG_IS_MASTER, {31'd0, mst});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic note_error(input string msg);
    if (err_cnt < 10) $display("%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // result check against the oldest awaited selection
  always @(posedge clk) begin : chk_results
    sel_res_t e;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pend_rd == pend_wr) begin
        note_error($sformatf("unexpected result frame=%h st=%0d",
                             out_chosen_frame, out_status));
      end else begin
        e = awaited_sel[pend_rd % PEND_SLOTS];
        pend_rd++;
        if (out_send_ok !== e.send_ok || out_ready_res !== e.ready_res ||
            out_chosen_frame !== e.chosen || out_status !== e.status) begin
          note_error($sformatf("mismatch exp ok=%0d rdy=%0d frame=%h st=%0d got %0d %0d %h %0d",
                               e.send_ok, e.ready_res, e.chosen, e.status, out_send_ok,
                               out_ready_res, out_chosen_frame, out_status));
        end
      end
    end
  end

  // main sequence
  initial begin
    int phase_goal;
    logic [31:0] lo;
    logic [31:0] hi;
    bit mst;
    in_valid <= 1'b0;
    in_operation <= OP_CHECK_SEND;
    in_frame_id <= 32'd0;
    in_channel_value <= 32'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 4'd0;
    pwdata <= 32'd0;
    rst_n <= 1'b0;
    in_idle_pct = 22;
    out_idle_pct = 51;
    items_sent = 0;
    err_cnt = 0;
    pend_wr = 0;
    pend_rd = 0;
    dir_rows = 0;
    fs_head = 0;
    fs_count = 0;
    fs_prev = 32'd0;
    fs_prev_ok = 1'b0;
    fs_tgt = 32'd0;
    fs_tgt_ok = 1'b0;
    fs_low = LOW_PERIOD_RST;
    fs_high = HIGH_PERIOD_RST;
    fs_master = IS_MASTER_RST;
    prod_frame = 32'd0;
    ann_frame = 32'd0;

    // directed table, run at the register defaults
    add_row(OP_COMPUTE, 32'd0, 32'd0, 1, 1'b1, mk_res(1'b0, 1'b0, 32'd0, ST_OK));
    // no previous frame: channel value -1 latches nothing
    add_row(OP_POLL, 32'd0, 32'hFFFF_FFFF, 1, 1'b1, mk_res(1'b0, 1'b0, 32'd0, ST_OK));
    // take with no known target on an empty fifo
    add_row(OP_TAKE, 32'd0, 32'd0, 1, 1'b1, mk_res(1'b0, 1'b0, 32'd0, ST_NOT_FOUND));
    add_row(OP_COMPUTE, 32'd0, 32'd0, 1, 1'b1, mk_res(1'b0, 1'b0, 32'd1, ST_OK));
    add_row(OP_CHECK_SEND, 32'hFFFF_FFFF, 32'd0, 1, 1'b1, mk_res(1'b1, 1'b0, 32'd0, ST_OK));
    add_row(OP_CHECK_SEND, 32'd0, 32'd0, 1, 1'b1, mk_res(1'b1, 1'b0, 32'd0, ST_OK));
    add_row(OP_PUT, 32'hFFFF_FFFF, 32'd0, 1, 1'b1, mk_res(1'b0, 1'b0, 32'd0, ST_OK));
    // no multiple of the low period buffered
    add_row(OP_COMPUTE, 32'd0, 32'd0, 1, 1'b0, '0);
    add_row(OP_TAKE, 32'd0, 32'd0, 1, 1'b0, '0);
    // fill the fifo, then overflow
    add_row(OP_PUT, 32'd3, 32'd0, SEL_DEPTH, 1'b0, '0);
    add_row(OP_PUT, 32'd99, 32'd0, 1, 1'b1, mk_res(1'b0, 1'b0, 32'd0, ST_FULL));
    add_row(OP_COMPUTE, 32'd0, 32'd0, 1, 1'b0, '0);
    add_row(OP_POLL, 32'd0, 32'd10, 1, 1'b0, '0);
    add_row(OP_POLL, 32'd0, 32'd5, 1, 1'b0, '0);
    add_row(OP_TAKE, 32'd0, 32'd0, 1, 1'b0, '0);
    // same low period as the previous frame
    add_row(OP_COMPUTE, 32'd0, 32'd0, 1, 1'b0, '0);
    add_row(OP_POLL, 32'd0, 32'd10, 1, 1'b0, '0);
    add_row(OP_POLL, 32'd0, 32'h7FFF_FFFF, 1, 1'b0, '0);
    // target absent: fifo cleared
    add_row(OP_TAKE, 32'd0, 32'd0, 1, 1'b1,
            mk_res(1'b0, 1'b0, 32'h7FFF_FFFF, ST_NOT_FOUND));
    add_row(OP_PUT, 32'hFFFF_FFFF, 32'd0, 1, 1'b0, '0);
    add_row(OP_POLL, 32'd0, 32'hFFFF_FFFF, 1, 1'b0, '0);
    add_row(OP_TAKE, 32'd0, 32'd0, 1, 1'b0, '0);
    // previous frame plus one wraps
    add_row(OP_COMPUTE, 32'd0, 32'd0, 1, 1'b0, '0);
    add_row(OP_UNUSED_FIRST, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 1'b1,
            mk_res(1'b0, 1'b0, 32'd0, ST_OK));
    add_row(OP_UNUSED_LAST, 32'd0, 32'd0, 1, 1'b1, mk_res(1'b0, 1'b0, 32'd0, ST_OK));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < dir_rows; r++) begin
      for (int n = 0; n < dir_tab[r].reps; n++) begin
        send_req(dir_tab[r].op, dir_tab[r].fid + n, dir_tab[r].chan, dir_tab[r].typed,
                 dir_tab[r].res);
      end
    end

    // random phases, one register setting each
    for (int ph = 0; ph < 7; ph++) begin
      in_valid <= 1'b0;
      while (pend_rd != pend_wr) @(posedge clk);
      case (ph)
        0: begin lo = 32'd10; hi = 32'd1; mst = 1'b1; end
        1: begin lo = 32'hFFFF_FFFF; hi = 32'hFFFF_FFFF; mst = 1'b1; end
        2: begin lo = 32'd1; hi = 32'd1; mst = 1'b0; end
        3: begin lo = 32'd0; hi = 32'd0; mst = 1'b1; end
        4: begin lo = 32'd8; hi = 32'd3; mst = 1'b1; end
        5: begin lo = $urandom_range(2, 64); hi = $urandom_range(1, 8); mst = 1'b1; end
        default: begin
          lo = $urandom_range(2, 32);
          hi = $urandom_range(1, 4);
          mst = 1'($urandom_range(1));
        end
      endcase
      cfg_apply(lo, hi, mst);
      if (ph < 3) begin
        in_idle_pct = 22;
        out_idle_pct = 51;
      end else if (ph < 5) begin
        in_idle_pct = 51;
        out_idle_pct = 22;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      prod_frame = ($urandom_range(3) == 0) ? 32'h7FFF_FFF0 : $urandom_range(1000);
      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) random_round();
    end

    in_valid <= 1'b0;
    while (pend_rd != pend_wr) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lhfs_pkg.sv
rtl/lhfs_divider.sv
rtl/low_high_frame_selector_top.sv
tb/low_high_frame_selector_top_tb.sv
